@@ sv/rrpt_pkg.sv @@
// Shared types, codes and constants for the round-robin process table.
package rrpt_pkg;

  localparam int unsigned DefMaxSlots = 16;
  localparam int unsigned PidW        = 32;
  localparam int unsigned PrioW       = 8;
  localparam int unsigned RunW        = 32;

  typedef enum logic [1:0] {
    OP_CREATE    = 2'd0,
    OP_TERMINATE = 2'd1,
    OP_SCHEDULE  = 2'd2,
    OP_LOOKUP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PS_READY      = 2'd0,
    PS_RUNNING    = 2'd1,
    PS_BLOCKED    = 2'd2,
    PS_TERMINATED = 2'd3
  } pstat_e;

  // one table row
  typedef struct packed {
    logic [PidW-1:0]  pid;
    pstat_e           status;
    logic [PrioW-1:0] prio;
    logic [RunW-1:0]  runs;
  } slot_t;

  // datapath operation for the current cycle
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_CREATE,
    DP_SRCH_RD,
    DP_SRCH_MISS,
    DP_HIT,
    DP_SHIFT_RD,
    DP_SHIFT_WR,
    DP_CLR_RD,
    DP_CLR_WR,
    DP_ADV,
    DP_MOD,
    DP_SCAN_RD,
    DP_SCAN_MISS,
    DP_RUN_WR,
    DP_FIN_RD,
    DP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;          // captured opcode
    logic full;        // table holds MAX_SLOTS entries
    logic empty;       // no entries
    logic cur_valid;   // a current process is marked
    logic idx_end;     // search index has passed the live entries
    logic idx_last;    // search index is the last live entry
    logic shift_last;  // this shift write is the final one
    logic match;       // read row carries the target id
    logic rot_wrap;    // rotating index + 1 lies above the live count
    logic mod_last;    // final remainder step
    logic slot_ready;  // read row is ready
    logic scan_last;   // final scan step of this tick
    logic out_free;    // result register can take a new item
  } dp_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_CREATE,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_CLR_RD,
    S_CLR_WR,
    S_ADV,
    S_MOD,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_RUN_WR,
    S_FIN_RD,
    S_DONE
  } ctrl_state_e;

endpackage

@@ sv/rrpt_ctrl.sv @@
// Sequencer for the process table: walks each operation through its steps.
module rrpt_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  rrpt_pkg::dp_status_t    status_i,
  output rrpt_pkg::dp_cmd_t       cmd_o
);
  import rrpt_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (status_i.op)
          OP_CREATE:    state_d = status_i.full ? S_FIN_RD : S_CREATE;
          OP_SCHEDULE: begin
            if (status_i.empty)          state_d = S_FIN_RD;
            else if (status_i.cur_valid) state_d = S_CLR_RD;
            else                         state_d = S_ADV;
          end
          default:      state_d = S_SRCH_RD;
        endcase
      end
      S_CREATE:   state_d = S_FIN_RD;
      S_SRCH_RD:  state_d = status_i.idx_end ? S_FIN_RD : S_SRCH_CHK;
      S_SRCH_CHK: begin
        if (!status_i.match) begin
          state_d = S_SRCH_RD;
        end else if (status_i.op == OP_TERMINATE && !status_i.idx_last) begin
          state_d = S_SHIFT_RD;
        end else begin
          state_d = S_FIN_RD;
        end
      end
      S_SHIFT_RD: state_d = S_SHIFT_WR;
      S_SHIFT_WR: state_d = status_i.shift_last ? S_FIN_RD : S_SHIFT_RD;
      S_CLR_RD:   state_d = S_CLR_WR;
      S_CLR_WR:   state_d = S_ADV;
      S_ADV:      state_d = status_i.rot_wrap ? S_MOD : S_SCAN_RD;
      S_MOD:      state_d = status_i.mod_last ? S_SCAN_RD : S_MOD;
      S_SCAN_RD:  state_d = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (status_i.slot_ready)      state_d = S_RUN_WR;
        else if (status_i.scan_last)  state_d = S_FIN_RD;
        else                          state_d = S_ADV;
      end
      S_RUN_WR:   state_d = S_FIN_RD;
      S_FIN_RD:   state_d = S_DONE;
      S_DONE: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = DP_NOP;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = DP_LOAD;
      end
      S_DISPATCH: cmd_o.op = DP_NOP;
      S_CREATE:   cmd_o.op = DP_CREATE;
      S_SRCH_RD:  cmd_o.op = status_i.idx_end ? DP_NOP : DP_SRCH_RD;
      S_SRCH_CHK: cmd_o.op = status_i.match ? DP_HIT : DP_SRCH_MISS;
      S_SHIFT_RD: cmd_o.op = DP_SHIFT_RD;
      S_SHIFT_WR: cmd_o.op = DP_SHIFT_WR;
      S_CLR_RD:   cmd_o.op = DP_CLR_RD;
      S_CLR_WR:   cmd_o.op = DP_CLR_WR;
      S_ADV:      cmd_o.op = DP_ADV;
      S_MOD:      cmd_o.op = DP_MOD;
      S_SCAN_RD:  cmd_o.op = DP_SCAN_RD;
      S_SCAN_CHK: cmd_o.op = status_i.slot_ready ? DP_NOP : DP_SCAN_MISS;
      S_RUN_WR:   cmd_o.op = DP_RUN_WR;
      S_FIN_RD:   cmd_o.op = DP_FIN_RD;
      S_DONE:     cmd_o.op = status_i.out_free ? DP_EMIT : DP_NOP;
      default:    cmd_o.op = DP_NOP;
    endcase
  end

endmodule

@@ sv/rrpt_dp.sv @@
// Datapath for the process table: slot memory, counters, remainder unit, result register.
module rrpt_dp #(
  parameter  int unsigned MAX_SLOTS = rrpt_pkg::DefMaxSlots,
  localparam int unsigned IdxW      = $clog2(MAX_SLOTS),
  localparam int unsigned CntW      = $clog2(MAX_SLOTS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rrpt_pkg::op_e                 in_op_i,
  input  logic [rrpt_pkg::PidW-1:0]     in_pid_i,
  input  logic [rrpt_pkg::PrioW-1:0]    in_prio_i,
  input  rrpt_pkg::dp_cmd_t             cmd_i,
  output rrpt_pkg::dp_status_t          status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [rrpt_pkg::PidW-1:0]     created_pid_o,
  output logic [rrpt_pkg::PidW-1:0]     running_pid_o,
  output logic                          found_o,
  output logic [1:0]                    found_state_o,
  output logic [rrpt_pkg::PrioW-1:0]    found_priority_o,
  output logic [rrpt_pkg::RunW-1:0]     found_run_count_o,
  output logic [CntW-1:0]               live_count_o
);
  import rrpt_pkg::*;

  localparam int unsigned ModCntW = $clog2(CntW);

  // slot memory, one row per process
  slot_t mem [MAX_SLOTS];
  slot_t rd_q;

  // control state
  op_e              op_q;
  logic [CntW-1:0]  count_q;
  logic [PidW-1:0]  next_id_q;
  logic [IdxW-1:0]  cur_slot_q;
  logic             cur_valid_q;
  logic [IdxW-1:0]  rot_q;
  logic [CntW-1:0]  idx_q;
  logic [CntW-1:0]  k_q;
  logic [ModCntW-1:0] mod_cnt_q;
  logic             out_valid_q;

  // payload
  logic [PidW-1:0]  pid_q;
  logic [PrioW-1:0] prio_q;
  logic [PidW-1:0]  created_q;
  logic             found_q;
  pstat_e           fstate_q;
  logic [PrioW-1:0] fprio_q;
  logic [RunW-1:0]  fruns_q;
  logic [CntW-1:0]  rem_q;
  logic [CntW-1:0]  mod_val_q;

  logic [PidW-1:0]  o_created_q, o_running_q;
  logic             o_found_q;
  pstat_e           o_fstate_q;
  logic [PrioW-1:0] o_fprio_q;
  logic [RunW-1:0]  o_fruns_q;
  logic [CntW-1:0]  o_live_q;

  // memory port controls
  logic             wr_en, rd_en;
  logic [IdxW-1:0]  wr_addr, rd_addr;
  slot_t            wr_data;

  // derived values
  logic [CntW:0]    idx_p1, idx_p2, cnt_x, k_p1, trial, new_rem;
  logic [CntW-1:0]  rot_v;
  logic [IdxW-1:0]  idx_a;
  logic             emit;

  assign idx_a   = idx_q[IdxW-1:0];
  assign idx_p1  = {1'b0, idx_q} + (CntW+1)'(1);
  assign idx_p2  = {1'b0, idx_q} + (CntW+1)'(2);
  assign cnt_x   = {1'b0, count_q};
  assign k_p1    = {1'b0, k_q} + (CntW+1)'(1);
  assign rot_v   = CntW'(rot_q) + CntW'(1);
  assign trial   = {rem_q, mod_val_q[CntW-1]};
  assign new_rem = (trial >= cnt_x) ? (trial - cnt_x) : trial;
  assign emit    = (cmd_i.op == DP_EMIT);

  always_comb begin
    status_o.op         = op_q;
    status_o.full       = (count_q == CntW'(MAX_SLOTS));
    status_o.empty      = (count_q == '0);
    status_o.cur_valid  = cur_valid_q;
    status_o.idx_end    = (idx_q >= count_q);
    status_o.idx_last   = (idx_p1 >= cnt_x);
    status_o.shift_last = (idx_p2 >= cnt_x);
    status_o.match      = (rd_q.pid == pid_q);
    status_o.rot_wrap   = (rot_v > count_q);
    status_o.mod_last   = (mod_cnt_q == '0);
    status_o.slot_ready = (rd_q.status == PS_READY);
    status_o.scan_last  = (k_p1 == cnt_x);
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  // memory port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_a;
    wr_data = rd_q;
    rd_en   = 1'b0;
    rd_addr = idx_a;
    case (cmd_i.op)
      DP_CREATE: begin
        wr_en          = 1'b1;
        wr_addr        = count_q[IdxW-1:0];
        wr_data.pid    = next_id_q;
        wr_data.status = PS_READY;
        wr_data.prio   = prio_q;
        wr_data.runs   = '0;
      end
      DP_SRCH_RD:  rd_en = 1'b1;
      DP_HIT: begin
        wr_en          = (op_q == OP_TERMINATE);
        wr_data.status = PS_TERMINATED;
      end
      DP_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_p1[IdxW-1:0];
      end
      DP_SHIFT_WR: wr_en = 1'b1;
      DP_CLR_RD: begin
        rd_en   = 1'b1;
        rd_addr = cur_slot_q;
      end
      DP_CLR_WR: begin
        wr_en          = 1'b1;
        wr_addr        = cur_slot_q;
        wr_data.status = PS_READY;
      end
      DP_SCAN_RD: begin
        rd_en   = 1'b1;
        rd_addr = rot_q;
      end
      DP_RUN_WR: begin
        wr_en          = 1'b1;
        wr_addr        = rot_q;
        wr_data.status = PS_RUNNING;
        wr_data.runs   = rd_q.runs + RunW'(1);
      end
      DP_FIN_RD: begin
        rd_en   = 1'b1;
        rd_addr = cur_slot_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= OP_CREATE;
      count_q     <= '0;
      next_id_q   <= PidW'(1);
      cur_slot_q  <= '0;
      cur_valid_q <= 1'b0;
      rot_q       <= '0;
      idx_q       <= '0;
      k_q         <= '0;
      mod_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        DP_LOAD: begin
          op_q  <= in_op_i;
          idx_q <= '0;
          k_q   <= '0;
        end
        DP_CREATE: begin
          next_id_q <= next_id_q + PidW'(1);
          count_q   <= count_q + CntW'(1);
        end
        DP_SRCH_MISS: idx_q <= idx_p1[CntW-1:0];
        DP_HIT: begin
          if (op_q == OP_TERMINATE && status_o.idx_last) count_q <= count_q - CntW'(1);
        end
        DP_SHIFT_WR: begin
          idx_q <= idx_p1[CntW-1:0];
          if (status_o.shift_last) count_q <= count_q - CntW'(1);
        end
        DP_ADV: begin
          if (status_o.rot_wrap)     mod_cnt_q <= ModCntW'(CntW - 1);
          else if (rot_v == count_q) rot_q     <= '0;
          else                       rot_q     <= rot_v[IdxW-1:0];
        end
        DP_MOD: begin
          mod_cnt_q <= mod_cnt_q - ModCntW'(1);
          if (status_o.mod_last) rot_q <= new_rem[IdxW-1:0];
        end
        DP_SCAN_MISS: k_q <= k_p1[CntW-1:0];
        DP_RUN_WR: begin
          cur_slot_q  <= rot_q;
          cur_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        pid_q     <= in_pid_i;
        prio_q    <= in_prio_i;
        created_q <= '0;
        found_q   <= 1'b0;
        fstate_q  <= PS_READY;
        fprio_q   <= '0;
        fruns_q   <= '0;
      end
      DP_CREATE: created_q <= next_id_q;
      DP_HIT: begin
        found_q <= 1'b1;
        if (op_q == OP_TERMINATE) begin
          fstate_q <= PS_TERMINATED;
        end else begin
          fstate_q <= rd_q.status;
          fprio_q  <= rd_q.prio;
          fruns_q  <= rd_q.runs;
        end
      end
      DP_ADV: begin
        mod_val_q <= rot_v;
        rem_q     <= '0;
      end
      DP_MOD: begin
        rem_q     <= new_rem[CntW-1:0];
        mod_val_q <= mod_val_q << 1;
      end
      DP_EMIT: begin
        o_created_q <= created_q;
        o_running_q <= cur_valid_q ? rd_q.pid : '0;
        o_found_q   <= found_q;
        o_fstate_q  <= fstate_q;
        o_fprio_q   <= fprio_q;
        o_fruns_q   <= fruns_q;
        o_live_q    <= count_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign created_pid_o     = o_created_q;
  assign running_pid_o     = o_running_q;
  assign found_o           = o_found_q;
  assign found_state_o     = o_fstate_q;
  assign found_priority_o  = o_fprio_q;
  assign found_run_count_o = o_fruns_q;
  assign live_count_o      = o_live_q;

endmodule

@@ sv/round_robin_process_table_core.sv @@
// Top level of the round-robin process table: sequencer, datapath and stream ports.
//
//  channel   dir  handshake               payload
//  --------  ---  ----------------------  -----------------------------------------------
//  s_axis    in   tvalid_i / tready_o     tuser: opcode; tdata: target_pid, new_priority
//  m_axis    out  tvalid_o / tready_i     tdata: created_pid .. live_count (see port)
//
//  One item at a time. Create writes a new row unless the table is full; lookup/terminate
//  search the live rows in order, and a terminate hit shifts the later rows down; schedule
//  returns the current process to ready, then scans on from the rotating index (remainder
//  steps run only when the rotating index lies beyond the live count, at most once per tick).
//  The slot memory has a registered read: every row visit is a read then a check.
//  Reset clears counters and markers only; slot row contents are never used before written.
//  A result waiting in the output register does not block the next item's intake; the
//  item after it holds in its last step until the register drains.
module round_robin_process_table_core #(
  parameter  int unsigned MAX_SLOTS = rrpt_pkg::DefMaxSlots,
  localparam int unsigned CntW      = $clog2(MAX_SLOTS + 1),
  localparam int unsigned OutBits   = 107 + CntW,
  localparam int unsigned OutW      = ((OutBits + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [39:0]      s_axis_tdata_i,   // target_pid[31:0], new_priority[39:32]
  input  logic [1:0]       s_axis_tuser_i,   // opcode[1:0]
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OutW-1:0]  m_axis_tdata_o    // created_pid, running_pid, found,
                                             // found_state, found_priority,
                                             // found_run_count, live_count, zero pad
);
  import rrpt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  logic [PidW-1:0]  created_pid, running_pid;
  logic             found;
  logic [1:0]       found_state;
  logic [PrioW-1:0] found_priority;
  logic [RunW-1:0]  found_run_count;
  logic [CntW-1:0]  live_count;

  rrpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rrpt_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_op_i           (op_e'(s_axis_tuser_i)),
    .in_pid_i          (s_axis_tdata_i[31:0]),
    .in_prio_i         (s_axis_tdata_i[39:32]),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_ready_i       (m_axis_tready_i),
    .out_valid_o       (m_axis_tvalid_o),
    .created_pid_o     (created_pid),
    .running_pid_o     (running_pid),
    .found_o           (found),
    .found_state_o     (found_state),
    .found_priority_o  (found_priority),
    .found_run_count_o (found_run_count),
    .live_count_o      (live_count)
  );

  // pack results, lowest field first
  assign m_axis_tdata_o = OutW'({live_count, found_run_count, found_priority,
                                 found_state, found, running_pid, created_pid});

`ifndef SYNTH
  // an accepted item keeps the intake closed on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("intake open straight after accepting an item");

  // a create result never reports a match
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (created_pid != '0)) |-> !found)
    else $error("create result carries a match flag");

  // live count never exceeds the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (live_count <= CntW'(MAX_SLOTS)))
    else $error("live count above table size");
`endif

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the round-robin process table core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rrpt_pkg::*;

  localparam int unsigned Slots    = DefMaxSlots;
  localparam int unsigned CntW     = $clog2(Slots + 1);
  localparam int unsigned OutW     = ((107 + CntW + 7) / 8) * 8;
  localparam int unsigned NumRand  = 550;
  localparam int unsigned CalmTail = 100;      // final items sent with no idling
  localparam int unsigned DrainWait = 100;     // above the longest single operation
  localparam int unsigned CycleLimit = 300000;

  // one result item as the block should report it
  typedef struct {
    logic [31:0]     created;
    logic [31:0]     running;
    logic            found;
    logic [1:0]      fstate;
    logic [7:0]      fprio;
    logic [31:0]     fruns;
    logic [CntW-1:0] live;
  } outcome_t;

  // Keeps its own copy of the process table, predicts one outcome per accepted
  // item and checks the outcomes in order.
  class pid_table_scoreboard;
    logic [31:0]  pid_q  [Slots];
    pstat_e       stat_q [Slots];
    logic [7:0]   prio_q [Slots];
    logic [31:0]  runs_q [Slots];
    int unsigned  live;
    logic [31:0]  id_next;
    int unsigned  cur_slot;
    bit           cur_valid;
    int unsigned  rot;
    outcome_t     expected_q[$];
    int unsigned  errors;
    int unsigned  checked;
    int unsigned  op_count[4];
    int unsigned  refused;
    int unsigned  hits;

    function new();
      for (int i = 0; i < Slots; i++) begin
        pid_q[i]  = '0;
        stat_q[i] = PS_TERMINATED;
        prio_q[i] = '0;
        runs_q[i] = '0;
      end
      live = 0;
      id_next = 32'd1;
      cur_slot = 0;
      cur_valid = 0;
      rot = 0;
      errors = 0;
      checked = 0;
      refused = 0;
      hits = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    // lowest live slot holding the id, or -1
    function int slot_of(logic [31:0] pid);
      for (int i = 0; i < live; i++)
        if (pid_q[i] == pid) return i;
      return -1;
    endfunction

    function void note_item(op_e op, logic [31:0] pid, logic [7:0] prio);
      outcome_t o;
      int       where;
      o = '{default: '0};
      op_count[op]++;
      case (op)
        OP_CREATE: begin
          if (live < Slots) begin
            pid_q[live]  = id_next;
            stat_q[live] = PS_READY;
            prio_q[live] = prio;
            runs_q[live] = '0;
            o.created    = id_next;
            id_next      = id_next + 32'd1;
            live++;
          end else begin
            refused++;
          end
        end
        OP_TERMINATE: begin
          where = slot_of(pid);
          if (where >= 0) begin
            hits++;
            o.found  = 1'b1;
            o.fstate = PS_TERMINATED;
            stat_q[where] = PS_TERMINATED;
            // later rows slide down; the vacated top row keeps its old contents
            for (int i = where; i + 1 < live; i++) begin
              pid_q[i]  = pid_q[i+1];
              stat_q[i] = stat_q[i+1];
              prio_q[i] = prio_q[i+1];
              runs_q[i] = runs_q[i+1];
            end
            live--;
          end
        end
        OP_SCHEDULE: begin
          if (live != 0) begin
            if (cur_valid) stat_q[cur_slot] = PS_READY;
            for (int i = 0; i < live; i++) begin
              rot = (rot + 1) % live;
              if (stat_q[rot] == PS_READY) begin
                cur_slot    = rot;
                cur_valid   = 1'b1;
                stat_q[rot] = PS_RUNNING;
                runs_q[rot] = runs_q[rot] + 32'd1;
                break;
              end
            end
          end
        end
        default: begin
          where = slot_of(pid);
          if (where >= 0) begin
            hits++;
            o.found  = 1'b1;
            o.fstate = stat_q[where];
            o.fprio  = prio_q[where];
            o.fruns  = runs_q[where];
          end
        end
      endcase
      // the marker keeps its index, so it may name a shifted or stale row
      o.running = cur_valid ? pid_q[cur_slot] : 32'd0;
      o.live    = live[CntW-1:0];
      expected_q.push_back(o);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH result %0d %s: got %0h want %0h", checked, what, got, want);
      errors++;
    endtask

    task check_result(logic [OutW-1:0] d);
      outcome_t w;
      if (expected_q.size() == 0) begin
        report_mismatch("with nothing outstanding", d[31:0], 32'd0);
        return;
      end
      w = expected_q.pop_front();
      if (d[31:0] !== w.created)        report_mismatch("created_pid", d[31:0], w.created);
      if (d[63:32] !== w.running)       report_mismatch("running_pid", d[63:32], w.running);
      if (d[64] !== w.found)
        report_mismatch("found", 32'(d[64]), 32'(w.found));
      if (d[66:65] !== w.fstate)
        report_mismatch("found_state", 32'(d[66:65]), 32'(w.fstate));
      if (d[74:67] !== w.fprio)
        report_mismatch("found_priority", 32'(d[74:67]), 32'(w.fprio));
      if (d[106:75] !== w.fruns)        report_mismatch("found_run_count", d[106:75], w.fruns);
      if (d[107 +: CntW] !== w.live)
        report_mismatch("live_count", 32'(d[107 +: CntW]), 32'(w.live));
      // pad bits above live_count, if any
      if ((d >> (107 + CntW)) !== '0)
        report_mismatch("padding", 32'(d >> (107 + CntW)), 32'd0);
      checked++;
    endtask
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_valid = 1'b0;
  logic [39:0]      s_data = '0;
  logic [1:0]       s_user = '0;
  logic             m_ready = 1'b0;
  logic             s_axis_tready_o;
  logic             m_axis_tvalid_o;
  logic [OutW-1:0]  m_axis_tdata_o;

  bit idle_on = 1'b1;   // random gaps and stalls on both sides
  pid_table_scoreboard sb = new();

  always #5 clk_i = ~clk_i;

  round_robin_process_table_core #(.MAX_SLOTS(Slots)) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Offer one item, with an optional gap first; the item counts at the rising
  // edge where tvalid and tready are both high.
  task send_item(op_e op, logic [31:0] pid, logic [7:0] prio);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk_i);
      s_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_data  <= {prio, pid};
    s_user  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_item(op, pid, prio);
  endtask

  // Mostly a live id; sometimes an earlier-issued one, a random word or an extreme.
  function logic [31:0] pick_target();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6 && sb.live > 0) return sb.pid_q[$urandom_range(0, sb.live - 1)];
    if (r < 8 && sb.id_next > 1) return $urandom_range(1, sb.id_next - 1);
    if (r == 8) return $urandom();
    return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd0;
  endfunction

  function logic [7:0] pick_prio();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver: ready with random stall bursts while idling is on.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) sb.check_result(m_axis_tdata_o);
  end

  // Watchdog.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("timeout with %0d results outstanding", sb.expected_q.size());
    $display("simulation failed");
    $finish;
  end

  // Main sequence: directed corners, then phased random traffic.
  initial begin
    int   r;
    op_e  op;
    bit   grow;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table: schedule does nothing, searches miss
    send_item(OP_SCHEDULE, 32'd0, 8'h00);
    send_item(OP_LOOKUP, 32'd0, 8'hFF);
    send_item(OP_TERMINATE, 32'hFFFF_FFFF, 8'h00);
    // fill the table, priorities at both ends, then one create past full
    for (int i = 0; i < Slots; i++)
      send_item(OP_CREATE, 32'h0, (i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'hFF : 8'(i * 37));
    send_item(OP_CREATE, 32'hFFFF_FFFF, 8'hA5);
    send_item(OP_SCHEDULE, 32'h0, 8'h00);
    send_item(OP_SCHEDULE, 32'h0, 8'h00);
    send_item(OP_LOOKUP, sb.pid_q[sb.cur_slot], 8'h00);
    // retire the running process: marker keeps its index over the shifted row
    send_item(OP_TERMINATE, sb.pid_q[sb.cur_slot], 8'h00);
    send_item(OP_SCHEDULE, 32'h0, 8'h00);
    // retire the top entry, then look it up again
    send_item(OP_TERMINATE, sb.pid_q[sb.live - 1], 8'h00);
    send_item(OP_LOOKUP, sb.id_next - 32'd1, 8'h00);

    // random part alternates between filling and draining the table
    for (int k = 0; k < NumRand; k++) begin
      if (k == NumRand - CalmTail) idle_on = 1'b0;
      grow = ((k / 60) % 2) == 0;
      r = $urandom_range(0, 99);
      if (r < (grow ? 40 : 10))      op = OP_CREATE;
      else if (r < (grow ? 50 : 45)) op = OP_TERMINATE;
      else if (r < 78)               op = OP_SCHEDULE;
      else                           op = OP_LOOKUP;
      if (op == OP_TERMINATE || op == OP_LOOKUP)
        send_item(op, pick_target(), 8'($urandom_range(0, 255)));
      else
        send_item(op, $urandom(), pick_prio());
    end
    @(negedge clk_i);
    s_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("covered %0d create (%0d refused full), %0d terminate, %0d schedule, %0d lookup",
             sb.op_count[OP_CREATE], sb.refused, sb.op_count[OP_TERMINATE],
             sb.op_count[OP_SCHEDULE], sb.op_count[OP_LOOKUP]);
    $display("%0d results checked, %0d id hits, %0d mismatches",
             sb.checked, sb.hits, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ round_robin_process_table_core.f @@
sv/rrpt_pkg.sv
sv/rrpt_ctrl.sv
sv/rrpt_dp.sv
sv/round_robin_process_table_core.sv
verif/testbench.sv
